### sv/dtpm_pkg.sv
// Shared constants, phase codes and the parse state type for the date-time prefix matcher.
package dtpm_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int OUT_BITS    = 16;
    localparam int PHASE_BITS  = 4;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX =
        (LENGTH_BITS >= 16) ? LENGTH_BITS'(65535) : LENGTH_BITS'((2 ** LENGTH_BITS) - 1);

    localparam logic [PHASE_BITS-1:0] PH_DATE     = 4'd0;
    localparam logic [PHASE_BITS-1:0] PH_TIME     = 4'd1;
    localparam logic [PHASE_BITS-1:0] PH_AFTER_DT = 4'd2;
    localparam logic [PHASE_BITS-1:0] PH_AFTER_LT = 4'd3;
    localparam logic [PHASE_BITS-1:0] PH_FRAC0_DT = 4'd4;
    localparam logic [PHASE_BITS-1:0] PH_FRAC_DT  = 4'd5;
    localparam logic [PHASE_BITS-1:0] PH_FRAC0_LT = 4'd6;
    localparam logic [PHASE_BITS-1:0] PH_FRAC_LT  = 4'd7;
    localparam logic [PHASE_BITS-1:0] PH_OFF1     = 4'd8;
    localparam logic [PHASE_BITS-1:0] PH_OFF2     = 4'd9;
    localparam logic [PHASE_BITS-1:0] PH_OFF3     = 4'd10;
    localparam logic [PHASE_BITS-1:0] PH_OFF4     = 4'd11;
    localparam logic [PHASE_BITS-1:0] PH_OFF5     = 4'd12;

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UPPER_T = 8'h54;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // date-time positions of interest
    localparam logic [LENGTH_BITS-1:0] DT_LEN   = LENGTH_BITS'(19);
    localparam logic [LENGTH_BITS-1:0] YMD_LEN  = LENGTH_BITS'(10);
    localparam logic [LENGTH_BITS-1:0] LT_LEN   = LENGTH_BITS'(8);
    localparam logic [LENGTH_BITS-1:0] SPLIT_IX = LENGTH_BITS'(2);

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic [LENGTH_BITS-1:0] pos;
        logic [LENGTH_BITS-1:0] acc;
        logic                   fin;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase: PH_DATE, pos: '0, acc: '0, fin: 1'b0
    };

endpackage

### sv/dtpm_step.sv
// Next-state logic of the matcher: one byte against the current parse state.
module dtpm_step (
    input  dtpm_pkg::t_parse_state i_state,
    input  logic [7:0]             i_char,
    output dtpm_pkg::t_parse_state o_state
);

    logic [dtpm_pkg::LENGTH_BITS-1:0] idx;
    logic [dtpm_pkg::LENGTH_BITS-1:0] nxt;
    logic                             dig;
    logic                             zulu;
    logic                             sign;
    logic                             dt_fit;
    logic                             lt_fit;

    assign idx  = i_state.pos;
    assign nxt  = (idx < dtpm_pkg::LEN_MAX) ? idx + 1'b1 : dtpm_pkg::LEN_MAX;
    assign dig  = (i_char inside {[dtpm_pkg::CH_ZERO:dtpm_pkg::CH_NINE]});
    assign zulu = (i_char == dtpm_pkg::CH_UPPER_Z) || (i_char == dtpm_pkg::CH_LOWER_Z);
    assign sign = (i_char == dtpm_pkg::CH_PLUS) || (i_char == dtpm_pkg::CH_DASH);

    // character class of each date-time position; only read below index 19
    always_comb begin
        case (idx[4:0])
            5'd4, 5'd7:   dt_fit = (i_char == dtpm_pkg::CH_DASH);
            5'd10:        dt_fit = (i_char == dtpm_pkg::CH_UPPER_T) ||
                                   (i_char == dtpm_pkg::CH_LOWER_T) ||
                                   (i_char == dtpm_pkg::CH_SPACE);
            5'd13, 5'd16: dt_fit = (i_char == dtpm_pkg::CH_COLON);
            default:      dt_fit = dig;
        endcase
    end

    // standalone time: colons at positions 2 and 5
    always_comb begin
        case (idx[2:0])
            3'd2, 3'd5: lt_fit = (i_char == dtpm_pkg::CH_COLON);
            default:    lt_fit = dig;
        endcase
    end

    always_comb begin
        o_state = i_state;
        if (!i_state.fin) begin
            o_state.pos = nxt;
            case (i_state.phase)
                dtpm_pkg::PH_DATE: begin
                    if (idx >= dtpm_pkg::DT_LEN) begin
                        o_state.fin = 1'b1;
                    end else if (idx == dtpm_pkg::SPLIT_IX && i_char == dtpm_pkg::CH_COLON) begin
                        o_state.phase = dtpm_pkg::PH_TIME;
                    end else if (!dt_fit) begin
                        o_state.fin = 1'b1;
                    end else if (idx == dtpm_pkg::YMD_LEN - 1'b1) begin
                        o_state.acc = dtpm_pkg::YMD_LEN;
                    end else if (idx == dtpm_pkg::DT_LEN - 1'b1) begin
                        o_state.acc   = dtpm_pkg::DT_LEN;
                        o_state.phase = dtpm_pkg::PH_AFTER_DT;
                    end
                end
                dtpm_pkg::PH_TIME: begin
                    if (idx >= dtpm_pkg::LT_LEN || !lt_fit) begin
                        o_state.fin = 1'b1;
                    end else if (idx == dtpm_pkg::LT_LEN - 1'b1) begin
                        o_state.acc   = dtpm_pkg::LT_LEN;
                        o_state.phase = dtpm_pkg::PH_AFTER_LT;
                    end
                end
                dtpm_pkg::PH_AFTER_DT, dtpm_pkg::PH_FRAC_DT: begin
                    if (i_state.phase == dtpm_pkg::PH_AFTER_DT && i_char == dtpm_pkg::CH_DOT) begin
                        o_state.phase = dtpm_pkg::PH_FRAC0_DT;
                    end else if (i_state.phase == dtpm_pkg::PH_FRAC_DT && dig) begin
                        o_state.acc = nxt;
                    end else if (zulu) begin
                        o_state.acc = nxt;
                        o_state.fin = 1'b1;
                    end else if (sign) begin
                        o_state.phase = dtpm_pkg::PH_OFF1;
                    end else begin
                        o_state.fin = 1'b1;
                    end
                end
                dtpm_pkg::PH_AFTER_LT: begin
                    if (i_char == dtpm_pkg::CH_DOT) begin
                        o_state.phase = dtpm_pkg::PH_FRAC0_LT;
                    end else begin
                        o_state.fin = 1'b1;
                    end
                end
                dtpm_pkg::PH_FRAC0_DT, dtpm_pkg::PH_FRAC0_LT, dtpm_pkg::PH_FRAC_LT: begin
                    if (!dig) begin
                        o_state.fin = 1'b1;
                    end else begin
                        o_state.acc   = nxt;
                        o_state.phase = (i_state.phase == dtpm_pkg::PH_FRAC0_DT) ?
                                        dtpm_pkg::PH_FRAC_DT : dtpm_pkg::PH_FRAC_LT;
                    end
                end
                dtpm_pkg::PH_OFF1, dtpm_pkg::PH_OFF2, dtpm_pkg::PH_OFF4: begin
                    if (!dig) begin
                        o_state.fin = 1'b1;
                    end else begin
                        o_state.phase = i_state.phase + 1'b1;
                    end
                end
                dtpm_pkg::PH_OFF3: begin
                    if (i_char != dtpm_pkg::CH_COLON) begin
                        o_state.fin = 1'b1;
                    end else begin
                        o_state.phase = dtpm_pkg::PH_OFF4;
                    end
                end
                dtpm_pkg::PH_OFF5: begin
                    if (dig) begin
                        o_state.acc = nxt;
                    end
                    o_state.fin = 1'b1;
                end
                default: begin
                    o_state.fin = 1'b1;
                end
            endcase
        end
    end

endmodule

### sv/datetime_prefix_matcher.sv
// Top level of the streaming date-time prefix matcher.
//
//  channel   dir  tdata                  tlast      tuser
//  s_axis    in   [7:0] char_code        last_char  -
//  m_axis    out  [15:0] match_length    -          -
//
// One byte per cycle unless a last byte waits on a stalled result: a
// byte moves from the input register through the phase decode into the
// parse state, so a transfer can be taken every cycle. The result is
// registered. Reset (synchronous, active low) empties both registers
// and returns the parse state to the start of a string. A stalled
// result blocks only a further last byte; bytes before it keep flowing.
module datetime_prefix_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [15:0] match_length
);

    dtpm_pkg::t_parse_state r_state;
    dtpm_pkg::t_parse_state n_state;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic        r_out_valid;
    logic [dtpm_pkg::OUT_BITS-1:0] r_out_len;
    logic        proceed;

    dtpm_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (n_state)
    );

    // a last byte needs room in the result register
    assign proceed = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proceed;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= dtpm_pkg::PARSE_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (proceed) begin
                if (r_in_last) begin
                    r_state     <= dtpm_pkg::PARSE_RESET;
                    r_out_valid <= 1'b1;
                end else begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (proceed && r_in_last) begin
            r_out_len <= dtpm_pkg::OUT_BITS'(n_state.acc);
        end
    end

endmodule

### dv/tb_top.sv
// Testbench for the streaming date-time prefix matcher: directed and random strings, self-checked.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BYTES = 1520;
    localparam int CALM_BYTES   = 300;   // tail of the random part runs without idling
    localparam int HOLD_CYCLES  = 200;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;   // [7:0] char_code
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;        // [15:0] match_length

    // parse state of the predictor
    logic [dtpm_pkg::PHASE_BITS-1:0]  cur_phase = dtpm_pkg::PH_DATE;
    logic [dtpm_pkg::LENGTH_BITS-1:0] cur_pos = '0;
    logic [dtpm_pkg::LENGTH_BITS-1:0] cur_acc = '0;
    bit                               cur_done = 1'b0;

    logic [15:0] match_len_q[$];
    logic [7:0]  text_buf[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          random_bytes = 0;
    bit          idle_en = 1'b0;
    bit          hold_req = 1'b0;

    datetime_prefix_matcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dtpm_pkg::CH_ZERO && c <= dtpm_pkg::CH_NINE;
    endfunction

    // character classes of YYYY-MM-DD?HH:MM:SS by position
    function automatic bit fits_datetime(input int unsigned idx, input logic [7:0] c);
        case (idx)
            4, 7:    return c == dtpm_pkg::CH_DASH;
            10:      return c == dtpm_pkg::CH_UPPER_T || c == dtpm_pkg::CH_LOWER_T ||
                            c == dtpm_pkg::CH_SPACE;
            13, 16:  return c == dtpm_pkg::CH_COLON;
            default: return is_digit(c);
        endcase
    endfunction

    function automatic bit fits_time(input int unsigned idx, input logic [7:0] c);
        if (idx == 2 || idx == 5)
            return c == dtpm_pkg::CH_COLON;
        return is_digit(c);
    endfunction

    // Advance the predicted parse by one accepted byte; a last byte yields a match length.
    task automatic parse_byte(input logic [7:0] c, input bit is_last);
        logic [dtpm_pkg::LENGTH_BITS-1:0] idx;
        logic [dtpm_pkg::LENGTH_BITS-1:0] nxt;
        bit zulu;
        bit sign;
        idx  = cur_pos;
        nxt  = (cur_pos < dtpm_pkg::LEN_MAX) ? cur_pos + 1'b1 : dtpm_pkg::LEN_MAX;
        zulu = (c == dtpm_pkg::CH_UPPER_Z || c == dtpm_pkg::CH_LOWER_Z);
        sign = (c == dtpm_pkg::CH_PLUS || c == dtpm_pkg::CH_DASH);
        if (!cur_done) begin
            cur_pos = nxt;
            case (cur_phase)
                dtpm_pkg::PH_DATE: begin
                    if (idx >= dtpm_pkg::DT_LEN) begin
                        cur_done = 1'b1;
                    end else if (idx == dtpm_pkg::SPLIT_IX && c == dtpm_pkg::CH_COLON) begin
                        cur_phase = dtpm_pkg::PH_TIME;
                    end else if (!fits_datetime(idx, c)) begin
                        cur_done = 1'b1;
                    end else begin
                        if (idx == dtpm_pkg::YMD_LEN - 1) cur_acc = dtpm_pkg::YMD_LEN;
                        if (idx == dtpm_pkg::DT_LEN - 1) begin
                            cur_acc   = dtpm_pkg::DT_LEN;
                            cur_phase = dtpm_pkg::PH_AFTER_DT;
                        end
                    end
                end
                dtpm_pkg::PH_TIME: begin
                    if (idx >= dtpm_pkg::LT_LEN || !fits_time(idx, c)) begin
                        cur_done = 1'b1;
                    end else if (idx == dtpm_pkg::LT_LEN - 1) begin
                        cur_acc   = dtpm_pkg::LT_LEN;
                        cur_phase = dtpm_pkg::PH_AFTER_LT;
                    end
                end
                dtpm_pkg::PH_AFTER_DT, dtpm_pkg::PH_FRAC_DT: begin
                    if (cur_phase == dtpm_pkg::PH_AFTER_DT && c == dtpm_pkg::CH_DOT) begin
                        cur_phase = dtpm_pkg::PH_FRAC0_DT;
                    end else if (cur_phase == dtpm_pkg::PH_FRAC_DT && is_digit(c)) begin
                        cur_acc = nxt;
                    end else if (zulu) begin
                        cur_acc  = nxt;
                        cur_done = 1'b1;
                    end else if (sign) begin
                        cur_phase = dtpm_pkg::PH_OFF1;
                    end else begin
                        cur_done = 1'b1;
                    end
                end
                dtpm_pkg::PH_AFTER_LT: begin
                    if (c == dtpm_pkg::CH_DOT) cur_phase = dtpm_pkg::PH_FRAC0_LT;
                    else cur_done = 1'b1;
                end
                dtpm_pkg::PH_FRAC0_DT, dtpm_pkg::PH_FRAC0_LT, dtpm_pkg::PH_FRAC_LT: begin
                    if (!is_digit(c)) begin
                        cur_done = 1'b1;
                    end else begin
                        cur_acc   = nxt;
                        cur_phase = (cur_phase == dtpm_pkg::PH_FRAC0_DT) ?
                                    dtpm_pkg::PH_FRAC_DT : dtpm_pkg::PH_FRAC_LT;
                    end
                end
                dtpm_pkg::PH_OFF1, dtpm_pkg::PH_OFF2, dtpm_pkg::PH_OFF4: begin
                    if (!is_digit(c)) cur_done = 1'b1;
                    else cur_phase = cur_phase + 1'b1;
                end
                dtpm_pkg::PH_OFF3: begin
                    if (c != dtpm_pkg::CH_COLON) cur_done = 1'b1;
                    else cur_phase = dtpm_pkg::PH_OFF4;
                end
                dtpm_pkg::PH_OFF5: begin
                    if (is_digit(c)) cur_acc = nxt;
                    cur_done = 1'b1;
                end
                default: cur_done = 1'b1;
            endcase
        end
        if (is_last) begin
            match_len_q.push_back(16'(cur_acc));
            cur_phase = dtpm_pkg::PH_DATE;
            cur_pos   = '0;
            cur_acc   = '0;
            cur_done  = 1'b0;
        end
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One byte transfer on the input side, with an optional idle burst in front.
    task automatic send_byte(input logic [7:0] c, input bit is_last);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge i_clk); while (!s_tready);
        parse_byte(c, is_last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic push_digits(input int n);
        repeat (n) text_buf.push_back(8'($urandom_range(dtpm_pkg::CH_ZERO, dtpm_pkg::CH_NINE)));
    endtask

    function automatic logic [7:0] near_miss_char();
        case ($urandom_range(0, 9))
            0:       return dtpm_pkg::CH_DASH;
            1:       return dtpm_pkg::CH_COLON;
            2:       return dtpm_pkg::CH_DOT;
            3:       return dtpm_pkg::CH_UPPER_T;
            4:       return dtpm_pkg::CH_LOWER_Z;
            5:       return dtpm_pkg::CH_PLUS;
            6:       return dtpm_pkg::CH_SPACE;
            7:       return 8'(dtpm_pkg::CH_ZERO - 1);
            8:       return 8'(dtpm_pkg::CH_NINE + 1);
            default: return 8'($urandom_range(dtpm_pkg::CH_ZERO, dtpm_pkg::CH_NINE));
        endcase
    endfunction

    // Mostly well-formed date-time text, then truncated, corrupted or padded at random.
    task automatic make_random_text();
        int kind;
        int cut;
        int at;
        text_buf.delete();
        kind = int'($urandom_range(0, 9));
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom));
        end else if (kind <= 2) begin
            push_digits(2); text_buf.push_back(dtpm_pkg::CH_COLON);
            push_digits(2); text_buf.push_back(dtpm_pkg::CH_COLON);
            push_digits(2);
            if ($urandom_range(0, 1)) begin
                text_buf.push_back(dtpm_pkg::CH_DOT);
                push_digits($urandom_range(0, 6));
            end
        end else begin
            push_digits(4); text_buf.push_back(dtpm_pkg::CH_DASH);
            push_digits(2); text_buf.push_back(dtpm_pkg::CH_DASH);
            push_digits(2);
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 2))
                    0:       text_buf.push_back(dtpm_pkg::CH_UPPER_T);
                    1:       text_buf.push_back(dtpm_pkg::CH_LOWER_T);
                    default: text_buf.push_back(dtpm_pkg::CH_SPACE);
                endcase
                push_digits(2); text_buf.push_back(dtpm_pkg::CH_COLON);
                push_digits(2); text_buf.push_back(dtpm_pkg::CH_COLON);
                push_digits(2);
                if ($urandom_range(0, 1)) begin
                    text_buf.push_back(dtpm_pkg::CH_DOT);
                    push_digits($urandom_range(0, 9));
                end
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(dtpm_pkg::CH_UPPER_Z);
                    1: text_buf.push_back(dtpm_pkg::CH_LOWER_Z);
                    2: begin
                        text_buf.push_back($urandom_range(0, 1) ?
                                           dtpm_pkg::CH_PLUS : dtpm_pkg::CH_DASH);
                        push_digits(2); text_buf.push_back(dtpm_pkg::CH_COLON); push_digits(2);
                    end
                    default: ;
                endcase
            end
        end
        case ($urandom_range(0, 5))
            0: begin
                cut = int'($urandom_range(1, text_buf.size()));
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
            1: begin
                at = int'($urandom_range(0, text_buf.size() - 1));
                text_buf[at] = $urandom_range(0, 1) ? 8'($urandom) : near_miss_char();
            end
            2: begin
                repeat ($urandom_range(1, 4))
                    text_buf.push_back($urandom_range(0, 1) ? 8'($urandom) : near_miss_char());
            end
            default: ;
        endcase
    endtask

    task automatic test_complete_forms();
        send_text("1979-05-27");
        send_text("1979-05-27T07:32:00");
        send_text("1979-05-27t07:32:00.999999Z");
        send_text("1979-05-27 07:32:00-07:00");
        send_text("1979-05-27T07:32:00.5+07:00");
        send_text("1979-05-27T07:32:00z");
        send_text("07:32:00.5x");
        send_text("07:32:00Z");
    endtask

    task automatic test_partial_and_broken();
        send_text("1979-05-27T07:32:00+07:0");
        send_text("1979-05-27T07:32:00.");
        send_text("07:32:00.");
        send_text("1979-05-27T07:3");
        send_text("07:32");
        send_text("a");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Receiver holds off while strings keep coming, so the block backs up.
    task automatic test_output_stall();
        idle_en  = 1'b0;
        hold_req = 1'b1;
        repeat (6) begin
            send_text("07:32:00");
            send_text("2024-02-29");
        end
    endtask

    task automatic test_random_strings();
        while (random_bytes < RANDOM_BYTES) begin
            idle_en = (random_bytes < RANDOM_BYTES - CALM_BYTES) && ($urandom_range(0, 7) != 0);
            make_random_text();
            send_buf();
            random_bytes += text_buf.size();
        end
        idle_en = 1'b0;
    endtask

    // receiver side: random back-pressure bursts and one long hold-off on request
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (rst_n && m_tvalid && m_tready) begin
            if (match_len_q.size() == 0) begin
                report_error($sformatf("match length %0d with none expected", m_tdata));
            end else begin
                want = match_len_q.pop_front();
                if (m_tdata !== want)
                    report_error($sformatf("match length %0d, expected %0d", m_tdata, want));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;
        idle_en = 1'b1;
        test_complete_forms();
        test_partial_and_broken();
        test_output_stall();
        test_random_strings();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (match_len_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### datetime_prefix_matcher.f
sv/dtpm_pkg.sv
sv/dtpm_step.sv
sv/datetime_prefix_matcher.sv
dv/tb_top.sv
